// ----- rtl/tclr_pkg.sv -----
`timescale 1ns / 1ps

package tclr_pkg;

	// Line buffer geometry
	localparam int LINE_MAX_LEN = 64;
	localparam int ADDR_W       = $clog2(LINE_MAX_LEN);
	localparam int CNT_W        = $clog2(LINE_MAX_LEN + 1);

	// Field and register widths
	localparam int BYTE_W     = 8;
	localparam int TAG_W      = 63;
	localparam int TLEN_W     = 4;
	localparam int TIMEOUT_W  = 16;
	localparam int IDLE_W     = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 63;
	localparam int TAG_MAX    = 8;

	// Register reset values
	localparam logic [TLEN_W-1:0]    TLEN_RESET    = 4'd1;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd2000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TAG_CHARS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAG_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd2;

	// Characters
	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_BRACE = 8'h7B;
	localparam logic [BYTE_W-1:0] PRINT_LO   = 8'd32;
	localparam logic [BYTE_W-1:0] PRINT_HI   = 8'd126;

	typedef enum logic [1:0] {
		KIND_CMD     = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_IGNORED = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_SRD,
		ST_SCMP,
		ST_FRD,
		ST_FCMP,
		ST_ERD,
		ST_EOUT,
		ST_ONE
	} state_t;

	typedef struct packed {
		logic [TAG_W-1:0]     tag_chars;
		logic [TLEN_W-1:0]    tag_length;
		logic [TIMEOUT_W-1:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	function automatic logic is_print(input logic [BYTE_W-1:0] c);
		return (c >= PRINT_LO) && (c <= PRINT_HI);
	endfunction

	function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
		return r;
	endfunction

	// Tag character k; the top character has only seven stored bits
	function automatic logic [BYTE_W-1:0] tag_char(input logic [TAG_W-1:0] tag,
		input logic [2:0] k);
		logic [TAG_W:0] ext;
		ext = {1'b0, tag};
		return ext[{k, 3'b000} +: BYTE_W];
	endfunction

endpackage

// ----- rtl/tclr_ifs.sv -----
`timescale 1ns / 1ps

interface tclr_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] data_byte;

	modport source (output valid, output operation, output data_byte, input ready);
	modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface tclr_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] command_byte;
	logic       last;

	modport source (output valid, output kind, output command_byte, output last,
		input ready);
	modport sink   (input valid, input kind, input command_byte, input last,
		output ready);
endinterface

interface tclr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [62:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/tclr_line_mem.sv -----
`timescale 1ns / 1ps

module tclr_line_mem (
	input  logic                         clk,
	input  tclr_pkg::mem_req_t           req,
	output logic [tclr_pkg::BYTE_W-1:0]  rdata
);

	logic [tclr_pkg::BYTE_W-1:0] mem [tclr_pkg::LINE_MAX_LEN];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Hold read data until the next read
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ----- rtl/tclr_ctrl.sv -----
`timescale 1ns / 1ps

module tclr_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	tclr_in_if.sink                     in_ch,
	tclr_out_if.source                  out_ch,
	input  tclr_pkg::cfg_t              cfg,
	output tclr_pkg::mem_req_t          mem_req,
	input  logic [tclr_pkg::BYTE_W-1:0] mem_rdata
);

	localparam int CW = tclr_pkg::CNT_W;
	localparam int AW = tclr_pkg::ADDR_W;
	localparam int IW = tclr_pkg::IDLE_W;
	localparam int TW = tclr_pkg::TLEN_W;

	tclr_pkg::state_t state_q, state_d;

	logic [CW-1:0]  cnt_q, len_q, pos_q, start_q, stop_q;
	logic [IW-1:0]  idle_q;
	logic [TW-1:0]  k_q;
	tclr_pkg::kind_t single_kind_q;

	logic            out_valid_q;
	tclr_pkg::kind_t out_kind_q;
	logic [7:0]      out_byte_q;
	logic            out_last_q;

	logic [TW-1:0] tlen, k_next;
	logic          tag_bad;
	logic          accept, is_byte, timed_out, store_ok, line_end, slot_free;
	logic [CW-1:0] cnt_eff, addr_sum, pos_inc;
	logic [7:0]    cur_tag;
	logic          char_match, tag_done, no_room, tag_long, last_byte, load_out;

	// Clamp tag length and flag tag characters that can never match
	always_comb begin
		tlen = (cfg.tag_length > TW'(tclr_pkg::TAG_MAX)) ? TW'(tclr_pkg::TAG_MAX)
			: cfg.tag_length;
		tag_bad = 1'b0;
		for (int k = 0; k < tclr_pkg::TAG_MAX; k++) begin
			if (TW'(k) < tlen &&
			    !tclr_pkg::is_print(tclr_pkg::tag_char(cfg.tag_chars, 3'(k)))) begin
				tag_bad = 1'b1;
			end
		end
	end

	assign accept    = in_ch.valid && in_ch.ready;
	assign is_byte   = accept && !in_ch.operation;
	assign timed_out = idle_q > IW'(cfg.timeout_ticks);
	assign cnt_eff   = timed_out ? '0 : cnt_q;
	assign store_ok  = tclr_pkg::is_print(in_ch.data_byte) &&
		(cnt_eff < CW'(tclr_pkg::LINE_MAX_LEN));
	assign line_end  = ((in_ch.data_byte == tclr_pkg::CHAR_LF) ||
		(in_ch.data_byte == tclr_pkg::CHAR_CR)) && (cnt_eff != '0);
	assign slot_free = !out_valid_q || out_ch.ready;

	assign addr_sum   = pos_q + CW'(k_q);
	assign pos_inc    = pos_q + CW'(1);
	assign k_next     = k_q + TW'(1);
	assign cur_tag    = tclr_pkg::tag_char(cfg.tag_chars, k_q[2:0]);
	assign char_match = tclr_pkg::fold_case(cur_tag) == tclr_pkg::fold_case(mem_rdata);
	assign tag_done   = k_next == tlen;
	assign no_room    = ((CW+1)'(pos_inc) + (CW+1)'(tlen)) > (CW+1)'(len_q);
	assign tag_long   = CW'(tlen) > len_q;
	assign last_byte  = pos_inc == stop_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tclr_pkg::ST_IDLE: begin
				if (is_byte && line_end) state_d = tclr_pkg::ST_START;
			end
			tclr_pkg::ST_START: begin
				if (tlen == '0) state_d = tclr_pkg::ST_FRD;
				else if (tag_bad || tag_long) state_d = tclr_pkg::ST_ONE;
				else state_d = tclr_pkg::ST_SRD;
			end
			tclr_pkg::ST_SRD: state_d = tclr_pkg::ST_SCMP;
			tclr_pkg::ST_SCMP: begin
				if (char_match) state_d = tag_done ? tclr_pkg::ST_FRD : tclr_pkg::ST_SRD;
				else state_d = no_room ? tclr_pkg::ST_ONE : tclr_pkg::ST_SRD;
			end
			tclr_pkg::ST_FRD: begin
				if (pos_q == len_q)
					state_d = (pos_q == start_q) ? tclr_pkg::ST_ONE : tclr_pkg::ST_ERD;
				else
					state_d = tclr_pkg::ST_FCMP;
			end
			tclr_pkg::ST_FCMP: begin
				if (mem_rdata == tclr_pkg::CHAR_BRACE)
					state_d = (pos_q == start_q) ? tclr_pkg::ST_ONE : tclr_pkg::ST_ERD;
				else
					state_d = tclr_pkg::ST_FRD;
			end
			tclr_pkg::ST_ERD: state_d = tclr_pkg::ST_EOUT;
			tclr_pkg::ST_EOUT: begin
				if (slot_free) state_d = last_byte ? tclr_pkg::ST_IDLE : tclr_pkg::ST_ERD;
			end
			tclr_pkg::ST_ONE: begin
				if (slot_free) state_d = tclr_pkg::ST_IDLE;
			end
			default: state_d = tclr_pkg::ST_IDLE;
		endcase
	end

	// State decodes
	always_comb begin
		in_ch.ready   = state_q == tclr_pkg::ST_IDLE;
		mem_req.we    = is_byte && store_ok;
		mem_req.waddr = cnt_eff[AW-1:0];
		mem_req.wdata = in_ch.data_byte;
		mem_req.re    = 1'b0;
		mem_req.raddr = pos_q[AW-1:0];
		load_out      = 1'b0;
		case (state_q)
			tclr_pkg::ST_SRD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = addr_sum[AW-1:0];
			end
			tclr_pkg::ST_FRD: mem_req.re = pos_q != len_q;
			tclr_pkg::ST_ERD: mem_req.re = 1'b1;
			tclr_pkg::ST_EOUT,
			tclr_pkg::ST_ONE: load_out = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tclr_pkg::ST_IDLE;
			cnt_q       <= '0;
			idle_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (in_ch.operation) begin
					if (idle_q != '1) idle_q <= idle_q + IW'(1);
				end else begin
					idle_q <= '0;
					cnt_q  <= line_end ? '0 : cnt_eff + CW'(store_ok);
				end
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// Search and emit datapath
	always_ff @(posedge clk) begin
		case (state_q)
			tclr_pkg::ST_IDLE: begin
				len_q <= cnt_eff;
			end
			tclr_pkg::ST_START: begin
				pos_q         <= '0;
				k_q           <= '0;
				start_q       <= '0;
				single_kind_q <= (tlen == '0) ? tclr_pkg::KIND_EMPTY : tclr_pkg::KIND_IGNORED;
			end
			tclr_pkg::ST_SCMP: begin
				if (char_match) begin
					k_q <= k_next;
					if (tag_done) begin
						start_q       <= pos_q + CW'(tlen);
						pos_q         <= pos_q + CW'(tlen);
						single_kind_q <= tclr_pkg::KIND_EMPTY;
					end
				end else begin
					pos_q <= pos_inc;
					k_q   <= '0;
				end
			end
			tclr_pkg::ST_FRD: begin
				if (pos_q == len_q) begin
					stop_q <= len_q;
					pos_q  <= start_q;
				end
			end
			tclr_pkg::ST_FCMP: begin
				if (mem_rdata == tclr_pkg::CHAR_BRACE) begin
					stop_q <= pos_q;
					pos_q  <= start_q;
				end else begin
					pos_q <= pos_inc;
				end
			end
			tclr_pkg::ST_EOUT: begin
				if (slot_free) pos_q <= pos_inc;
			end
			default: ;
		endcase
		if (load_out) begin
			if (state_q == tclr_pkg::ST_EOUT) begin
				out_kind_q <= tclr_pkg::KIND_CMD;
				out_byte_q <= mem_rdata;
				out_last_q <= last_byte;
			end else begin
				out_kind_q <= single_kind_q;
				out_byte_q <= '0;
				out_last_q <= 1'b1;
			end
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.kind         = out_kind_q;
	assign out_ch.command_byte = out_byte_q;
	assign out_ch.last         = out_last_q;

endmodule

// ----- rtl/tagged_command_line_receiver_top.sv -----
`timescale 1ns / 1ps

// Tagged command line receiver.
//
// in_ch carries received bytes (operation 0) and millisecond ticks
// (operation 1). out_ch returns command bytes of a line that holds the
// request tag, or one empty-command or line-ignored result; last marks the
// final result of a line. cfg_ch writes tag_chars, tag_length and
// timeout_ticks; index 3 is dropped. Write registers only while idle.
//
// in_ch is ready only while idle. A CR or LF ending a non-empty line starts
// the line sequencer, which owns the line memory: it compares up to
// tag_length characters per candidate tag position, reads each byte scanned
// for '{', then reads and emits each command byte, waiting on output stalls.
//
// Reset clears the line count, idle tick counter and output valid flag and
// loads the register defaults; the line memory is not cleared. When the
// receiver stalls, the output register holds its result and the sequencer
// waits; a new request is taken once the final result of a line is loaded.

module tagged_command_line_receiver_top (
	input  logic       clk,
	input  logic       arst_n,
	tclr_in_if.sink    in_ch,
	tclr_out_if.source out_ch,
	tclr_cfg_if.sink   cfg_ch
);

	tclr_pkg::cfg_t     cfg_q;
	tclr_pkg::mem_req_t mem_req;
	logic [tclr_pkg::BYTE_W-1:0] mem_rdata;

	// Registers accept a write every cycle
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tag_chars     <= '0;
			cfg_q.tag_length    <= tclr_pkg::TLEN_RESET;
			cfg_q.timeout_ticks <= tclr_pkg::TIMEOUT_RESET;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				tclr_pkg::REG_TAG_CHARS:  cfg_q.tag_chars     <= cfg_ch.data;
				tclr_pkg::REG_TAG_LENGTH: cfg_q.tag_length    <= cfg_ch.data[tclr_pkg::TLEN_W-1:0];
				tclr_pkg::REG_TIMEOUT:    cfg_q.timeout_ticks <= cfg_ch.data[tclr_pkg::TIMEOUT_W-1:0];
				default: ; // unused index: drop the write
			endcase
		end
	end

	// Byte intake, tag search and result sequencing
	tclr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg       (cfg_q),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	// Line buffer
	tclr_line_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule

// ----- rtl/tclr_checker.sv -----
`timescale 1ns / 1ps

module tclr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_operation,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_kind,
	input logic [7:0] out_byte,
	input logic       out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_kind) && $stable(out_byte) && $stable(out_last))
		else $error("result changed while stalled");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != tclr_pkg::KIND_CMD |-> out_last && out_byte == 8'd0)
		else $error("single result without last or with nonzero byte");

	a_busy_mid_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("request taken while a line is still being emitted");

	a_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_operation && !out_valid |=> !out_valid)
		else $error("tick produced a result");

endmodule

bind tagged_command_line_receiver_top tclr_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_operation (in_ch.operation),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_kind     (out_ch.kind),
	.out_byte     (out_ch.command_byte),
	.out_last     (out_ch.last)
);
